// ===== hw/rtl/pa_pkg.sv =====
// Shared types, mode codes and helpers for the primitive assembly block.
package pa_pkg;

    localparam int VERT_W   = 32;
    localparam int MODE_W   = 3;
    localparam int CORNER_W = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_POINTS     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LINE_STRIP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINE_LOOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LINES      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRI_STRIP  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TRI_FAN    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_TRIANGLES  = 3'd6;

    localparam logic [CORNER_W-1:0] CORNERS_NONE  = 2'd0;
    localparam logic [CORNER_W-1:0] CORNERS_POINT = 2'd1;
    localparam logic [CORNER_W-1:0] CORNERS_LINE  = 2'd2;
    localparam logic [CORNER_W-1:0] CORNERS_TRI   = 2'd3;

    typedef logic [VERT_W-1:0] t_vert;

    typedef struct packed {
        t_vert                vert_a;
        t_vert                vert_b;
        t_vert                vert_c;
        logic [CORNER_W-1:0]  corner_count;
        logic                 prim_valid;
        logic                 draw_done;
    } t_result;

    // Results produced by one accepted vertex: num is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic             ready;
        logic [LVL_W-1:0] level;
    } t_fifo_stat;

    function automatic t_result mk_prim(input t_vert a, input t_vert b, input t_vert c,
                                        input logic [CORNER_W-1:0] n);
        t_result r;
        r.vert_a       = a;
        r.vert_b       = b;
        r.vert_c       = c;
        r.corner_count = n;
        r.prim_valid   = (n != CORNERS_NONE);
        r.draw_done    = 1'b0;
        return r;
    endfunction

endpackage

// ===== hw/rtl/primitive_assembly.sv =====
// Top level of the primitive assembly block: vertex stream in, primitive stream out.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata vertex_index, tlast end_of_draw
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata vert_a..corner_count, tuser, tlast
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_data prim_mode
//
// One vertex is accepted per cycle while s_axis_tready is high; its results are queued
// and show on m_axis from the queue head. A line loop end vertex makes two results and
// the output drains one per cycle while m_axis_tready is high, so the four-entry result
// queue sets the input rate: a vertex is taken while the queue has room for two results.
// Reset (synchronous, active low) sets points mode, clears draw state and the queue.
// A stalled output holds its result; the input flows until the queue lacks room for two.
module primitive_assembly
    import pa_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // vertex_index[31:0]
    input  logic                 s_axis_tlast,   // end_of_draw
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [103:0]         m_axis_tdata,   // vert_a, vert_b, vert_c, corner_count, zeros
    output logic                 m_axis_tuser,   // prim_valid
    output logic                 m_axis_tlast,   // draw_done
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MODE_W-1:0]    i_cfg_data
);

    logic [MODE_W-1:0] r_mode;
    logic              take;
    t_push             push;
    t_result           head;
    t_fifo_stat        stat;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = stat.ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_POINTS;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    pa_assemble #(
        .INDEX_BITS(INDEX_BITS)
    ) u_assemble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_vertex (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_mode   (r_mode),
        .o_push   (push)
    );

    pa_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_stat  (stat)
    );

    assign m_axis_tdata = {6'd0, head.corner_count, head.vert_c, head.vert_b, head.vert_a};
    assign m_axis_tuser = head.prim_valid;
    assign m_axis_tlast = head.draw_done;

`ifndef SYNTHESIS
    a_push_only_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != 2'd0) |-> take)
        else $error("results pushed without an accepted vertex");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && s_axis_tlast) |-> (push.num != 2'd0))
        else $error("end vertex produced no result");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.level <= LVL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_take_shows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != 2'd0) |=> m_axis_tvalid)
        else $error("pushed result not presented");
`endif

endmodule

// ===== hw/rtl/pa_assemble.sv =====
// Draw state and primitive building for one vertex per cycle while i_take is high.
module pa_assemble
    import pa_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  t_vert             i_vertex,
    input  logic              i_last,
    input  logic [MODE_W-1:0] i_mode,
    output t_push             o_push
);

    logic [INDEX_BITS-1:0] r_first, r_prev, r_prev2;
    logic [1:0]            r_seen;
    logic                  r_parity;

    logic [INDEX_BITS-1:0] n_first;
    logic [1:0]            n_seen, sat;
    logic                  n_parity;
    logic [INDEX_BITS-1:0] v;
    t_vert                 vx, firstx, prevx, prev2x;
    t_push                 push;

    assign v      = i_vertex[INDEX_BITS-1:0];
    assign vx     = VERT_W'(v);
    assign firstx = VERT_W'(n_first);
    assign prevx  = VERT_W'(r_prev);
    assign prev2x = VERT_W'(r_prev2);
    assign sat    = (r_seen == 2'd3) ? 2'd3 : r_seen + 2'd1;

    always_comb begin
        n_first   = (r_seen == 2'd0) ? v : r_first;
        n_seen    = sat;
        n_parity  = r_parity;
        push.num  = 2'd0;
        push.res0 = mk_prim('0, '0, '0, CORNERS_NONE);
        push.res1 = mk_prim('0, '0, '0, CORNERS_NONE);
        case (i_mode)
            MODE_POINTS: begin
                push.num  = 2'd1;
                push.res0 = mk_prim(vx, '0, '0, CORNERS_POINT);
            end
            MODE_LINE_STRIP, MODE_LINE_LOOP: begin
                if (r_seen != 2'd0) begin
                    push.num  = 2'd1;
                    push.res0 = mk_prim(prevx, vx, '0, CORNERS_LINE);
                    // close the loop back to the first vertex
                    if (i_mode == MODE_LINE_LOOP && i_last) begin
                        push.num  = 2'd2;
                        push.res1 = mk_prim(vx, firstx, '0, CORNERS_LINE);
                    end
                end
            end
            MODE_LINES: begin
                if (r_seen != 2'd0) begin
                    push.num  = 2'd1;
                    push.res0 = mk_prim(prevx, vx, '0, CORNERS_LINE);
                    n_seen    = 2'd0;
                end else begin
                    n_seen = 2'd1;
                end
            end
            MODE_TRI_STRIP: begin
                if (r_seen >= 2'd2) begin
                    push.num  = 2'd1;
                    push.res0 = r_parity ? mk_prim(prevx, prev2x, vx, CORNERS_TRI)
                                         : mk_prim(prev2x, prevx, vx, CORNERS_TRI);
                    n_parity  = ~r_parity;
                end
            end
            MODE_TRI_FAN: begin
                if (r_seen >= 2'd2) begin
                    push.num  = 2'd1;
                    push.res0 = mk_prim(firstx, prevx, vx, CORNERS_TRI);
                end
            end
            MODE_TRIANGLES: begin
                if (r_seen >= 2'd2) begin
                    push.num  = 2'd1;
                    push.res0 = mk_prim(prev2x, prevx, vx, CORNERS_TRI);
                    n_seen    = 2'd0;
                end else begin
                    n_seen = r_seen + 2'd1;
                end
            end
            default: begin
                n_seen = sat;
            end
        endcase
        // end of draw: always at least one result, done on the final one
        if (i_last) begin
            if (push.num == 2'd0) begin
                push.num = 2'd1;
            end
            if (push.num == 2'd2) begin
                push.res1.draw_done = 1'b1;
            end else begin
                push.res0.draw_done = 1'b1;
            end
        end
        if (!i_take) begin
            push.num = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_prev   <= '0;
            r_prev2  <= '0;
            r_seen   <= 2'd0;
            r_parity <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                r_first  <= '0;
                r_prev   <= '0;
                r_prev2  <= '0;
                r_seen   <= 2'd0;
                r_parity <= 1'b0;
            end else begin
                r_first  <= n_first;
                r_prev   <= v;
                r_prev2  <= r_prev;
                r_seen   <= n_seen;
                r_parity <= n_parity;
            end
        end
    end

endmodule

// ===== hw/rtl/pa_out_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle on i_pop.
module pa_out_fifo
    import pa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_pop,
    output logic       o_valid,
    output t_result    o_head,
    output t_fifo_stat o_stat
);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [LVL_W-1:0] r_level;
    logic             pop;

    assign o_valid = (r_level != '0);
    assign pop     = i_pop && o_valid;
    assign o_head  = r_mem[r_rd];

    // room for two requests, whatever leaves this cycle
    assign o_stat.ready = (r_level <= LVL_W'(FIFO_DEPTH - 2));
    assign o_stat.level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.num);
            r_rd    <= r_rd + PTR_W'(pop);
            r_level <= r_level + LVL_W'(i_push.num) - LVL_W'(pop);
        end
    end

endmodule

// ===== dv/primitive_assembly_tb.sv =====
// Self-checking testbench for primitive_assembly: vertex draws in every mode, checked per result.
module primitive_assembly_tb;
    import pa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
    localparam int VERTEX_TARGET = 1250;
    localparam int IDLE_LIMIT    = 1000;
    localparam int PRINT_LIMIT   = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [103:0]         m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [MODE_W-1:0]    i_cfg_data = '0;

    primitive_assembly dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Assembly state tracked alongside the block
    logic [MODE_W-1:0] asm_mode = MODE_POINTS;
    t_vert             asm_first = '0;
    t_vert             asm_prev = '0;
    t_vert             asm_prev2 = '0;
    logic [1:0]        asm_seen = '0;
    logic              asm_parity = 1'b0;
    t_result           expected_prims[$];

    int  mismatches = 0;
    int  prims_checked = 0;
    int  vertices_sent = 0;
    int  draws_sent = 0;
    int  mode_writes = 0;
    int  drain_pauses = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  src_active = 1'b0;
    int  sink_cycle = 0;
    int  sink_style = 0;
    int  sink_hold = 0;
    bit  [7:0] modes_seen = '0;
    t_result want_prim;

    function automatic void push_prim(input t_vert a, input t_vert b, input t_vert c,
                                      input logic [CORNER_W-1:0] n);
        t_result r;
        r.vert_a       = a;
        r.vert_b       = b;
        r.vert_c       = c;
        r.corner_count = n;
        r.prim_valid   = (n != CORNERS_NONE);
        r.draw_done    = 1'b0;
        expected_prims.insert(expected_prims.size(), r);
    endfunction

    function automatic void assemble_vertex(input t_vert v, input logic last);
        logic [1:0] sat;
        int         made;
        sat  = (asm_seen < 2'd3) ? asm_seen + 2'd1 : 2'd3;
        made = expected_prims.size();
        if (asm_seen == 2'd0) asm_first = v;
        case (asm_mode)
            MODE_POINTS: begin
                push_prim(v, '0, '0, CORNERS_POINT);
                asm_seen = sat;
            end
            MODE_LINE_STRIP, MODE_LINE_LOOP: begin
                if (asm_seen >= 2'd1) push_prim(asm_prev, v, '0, CORNERS_LINE);
                // close the loop back to the first vertex of the draw
                if (asm_mode == MODE_LINE_LOOP && last && asm_seen >= 2'd1)
                    push_prim(v, asm_first, '0, CORNERS_LINE);
                asm_seen = sat;
            end
            MODE_LINES: begin
                if (asm_seen >= 2'd1) begin
                    push_prim(asm_prev, v, '0, CORNERS_LINE);
                    asm_seen = 2'd0;
                end else begin
                    asm_seen = 2'd1;
                end
            end
            MODE_TRI_STRIP: begin
                if (asm_seen >= 2'd2) begin
                    if (asm_parity) push_prim(asm_prev, asm_prev2, v, CORNERS_TRI);
                    else push_prim(asm_prev2, asm_prev, v, CORNERS_TRI);
                    asm_parity = ~asm_parity;
                end
                asm_seen = sat;
            end
            MODE_TRI_FAN: begin
                if (asm_seen >= 2'd2) push_prim(asm_first, asm_prev, v, CORNERS_TRI);
                asm_seen = sat;
            end
            MODE_TRIANGLES: begin
                if (asm_seen >= 2'd2) begin
                    push_prim(asm_prev2, asm_prev, v, CORNERS_TRI);
                    asm_seen = 2'd0;
                end else begin
                    asm_seen = asm_seen + 2'd1;
                end
            end
            default: asm_seen = sat;
        endcase
        asm_prev2 = asm_prev;
        asm_prev  = v;
        if (last) begin
            if (expected_prims.size() == made) push_prim('0, '0, '0, CORNERS_NONE);
            expected_prims[expected_prims.size() - 1].draw_done = 1'b1;
            asm_first  = '0;
            asm_prev   = '0;
            asm_prev2  = '0;
            asm_seen   = '0;
            asm_parity = 1'b0;
        end
    endfunction

    function automatic t_vert rand_index();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH result %0d %s: got %h expected %h",
                     prims_checked, what, got, want);
    endtask

    // Request one vertex; the sender works in bursts with random gaps between them
    task automatic send_vertex(input t_vert v, input logic last);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        src_active = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        assemble_vertex(v, last);
        vertices_sent++;
        if (last) draws_sent++;
        burst_left--;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            src_active = 1'b0;
        end
    endtask

    task automatic idle_input();
        if (src_active) begin
            s_axis_tvalid <= 1'b0;
            src_active = 1'b0;
        end
        burst_left = 0;
    endtask

    task automatic wait_drained();
        idle_input();
        while (expected_prims.size() != 0) @(posedge i_clk);
    endtask

    // Write the mode only once the block has gone quiet
    task automatic set_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        asm_mode = m;
        modes_seen[m] = 1'b1;
        mode_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_mode_basics();
        // points right out of reset, with extreme indices
        send_vertex('0, 1'b0);
        send_vertex('1, 1'b1);
        set_mode(MODE_LINE_STRIP);
        send_vertex(32'h5555_5555, 1'b0);
        send_vertex(32'hAAAA_AAAA, 1'b1);
        // leftover vertex dropped at the end
        set_mode(MODE_LINES);
        send_vertex(32'hAAAA_AAAA, 1'b0);
        send_vertex(32'h5555_5555, 1'b0);
        send_vertex('1, 1'b1);
        // both windings of the strip
        set_mode(MODE_TRI_STRIP);
        send_vertex(32'd1, 1'b0);
        send_vertex(32'd2, 1'b0);
        send_vertex(32'd3, 1'b0);
        send_vertex('1, 1'b1);
        set_mode(MODE_TRI_FAN);
        send_vertex(32'hAAAA_AAAA, 1'b0);
        send_vertex(32'd7, 1'b0);
        send_vertex(32'd8, 1'b0);
        send_vertex(32'h5555_5555, 1'b1);
        // end vertex completes nothing: empty end result
        set_mode(MODE_TRIANGLES);
        send_vertex('1, 1'b0);
        send_vertex(32'd0, 1'b0);
        send_vertex(32'h1234_5678, 1'b0);
        send_vertex(32'h9ABC_DEF0, 1'b1);
        set_mode(MODE_SPARE);
        send_vertex(32'hDEAD_BEEF, 1'b1);
    endtask

    task automatic test_line_loop_closing();
        set_mode(MODE_LINE_LOOP);
        // a single vertex gets no closing edge
        send_vertex(32'h0000_0042, 1'b1);
        send_vertex(32'hAAAA_AAAA, 1'b0);
        send_vertex(32'h5555_5555, 1'b0);
        send_vertex(32'h0F0F_0F0F, 1'b1);
    endtask

    task automatic test_mode_change_mid_draw();
        set_mode(MODE_LINES);
        send_vertex(32'h1111_1111, 1'b0);
        set_mode(MODE_TRIANGLES);
        send_vertex(32'h2222_2222, 1'b0);
        send_vertex(32'h3333_3333, 1'b1);
    endtask

    task automatic test_random_draws();
        int len;
        int split;
        while (vertices_sent < VERTEX_TARGET) begin
            set_mode(MODE_W'($urandom_range(0, 7)));
            repeat ($urandom_range(1, 6)) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48)
                                                   : $urandom_range(1, 12);
                split = ($urandom_range(0, 11) == 0 && len > 1) ? $urandom_range(1, len - 1)
                                                                : 0;
                for (int i = 0; i < len; i++) begin
                    if (split != 0 && i == split) set_mode(MODE_W'($urandom_range(0, 7)));
                    send_vertex(rand_index(), i == len - 1);
                end
                // at random, hold the sender until every primitive has come out
                if ($urandom_range(0, 14) == 0) begin
                    wait_drained();
                    drain_pauses++;
                end
            end
        end
    endtask

    // Sink: switch stall style every so often
    always @(posedge i_clk) begin
        if (sink_cycle % 150 == 0) sink_style = $urandom_range(0, 3);
        case (sink_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (sink_cycle % 4 == 0);
            default: begin
                if (sink_hold > 0) begin
                    sink_hold--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) sink_hold = $urandom_range(5, 30);
                end
            end
        endcase
        sink_cycle++;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_prims.size() == 0) begin
                report_mismatch("unexpected result, vert_a", m_axis_tdata[31:0], '0);
            end else begin
                want_prim = expected_prims.pop_front();
                if (m_axis_tdata[31:0] !== want_prim.vert_a)
                    report_mismatch("vert_a", m_axis_tdata[31:0], want_prim.vert_a);
                if (m_axis_tdata[63:32] !== want_prim.vert_b)
                    report_mismatch("vert_b", m_axis_tdata[63:32], want_prim.vert_b);
                if (m_axis_tdata[95:64] !== want_prim.vert_c)
                    report_mismatch("vert_c", m_axis_tdata[95:64], want_prim.vert_c);
                if (m_axis_tdata[97:96] !== want_prim.corner_count)
                    report_mismatch("corner_count", m_axis_tdata[97:96],
                                    want_prim.corner_count);
                if (m_axis_tdata[103:98] !== '0)
                    report_mismatch("tdata padding", m_axis_tdata[103:98], '0);
                if (m_axis_tuser !== want_prim.prim_valid)
                    report_mismatch("prim_valid", m_axis_tuser, want_prim.prim_valid);
                if (m_axis_tlast !== want_prim.draw_done)
                    report_mismatch("draw_done", m_axis_tlast, want_prim.draw_done);
            end
            prims_checked++;
        end
    end

    // Watchdog: end the run if no request moves on any channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: %0d results still expected", expected_prims.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_mode_basics();
        test_line_loop_closing();
        test_mode_change_mid_draw();
        test_random_draws();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d vertices in %0d draws, %0d primitives checked",
                 vertices_sent, draws_sent, prims_checked);
        $display("Mode writes %0d (modes hit mask %b), sender drain pauses %0d",
                 mode_writes, modes_seen, drain_pauses);
        if (mismatches == 0 && expected_prims.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
